// File: design/tcw_pkg.sv
package tcw_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_MOVE  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } t_state;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    localparam logic [15:0] BLANK_RESET = 16'h0F20;
    localparam logic [3:0]  FG_RESET    = 4'd15;
    localparam logic [3:0]  BG_RESET    = 4'd0;

    typedef struct packed {
        logic exec;
        logic sweep;
        logic init;
        logic load;
        logic load_read;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic scroll;
        logic last;
    } t_sts;

endpackage

// File: design/tcw_ctrl.sv
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_room;
    logic   w_accept;

    assign w_room   = (r_state == ST_IDLE) && (!r_out_valid || !i_out_stall);
    assign w_accept = w_room && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_sts.op == OP_READ) begin
                        n_state = ST_READ;
                    end else if (i_sts.op == OP_CLEAR ||
                                 (i_sts.op == OP_PUT && i_sts.scroll)) begin
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                if (i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
                o_cmd.init  = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.exec = w_accept;
                o_cmd.load = w_accept && (i_sts.op == OP_MOVE ||
                                          (i_sts.op == OP_PUT && !i_sts.scroll));
            end
            ST_READ: begin
                o_cmd.load      = 1'b1;
                o_cmd.load_read = 1'b1;
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                o_cmd.load  = i_sts.last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !w_room;
    assign o_out_valid = r_out_valid;

endmodule

// File: design/tcw_dp.sv
module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [1:0]            i_operation,
    input  logic [7:0]            i_char_code,
    input  logic [6:0]            i_column,
    input  logic [4:0]            i_row,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [10:0]           o_cursor_position,
    output logic [15:0]           o_cell_value
);

    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int TW     = $clog2(COLUMNS + TAB_WIDTH);
    localparam int NSTOPS = (COLUMNS - 1) / TAB_WIDTH + 1;

    logic [15:0]   r_mem [CELLS];
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [RW-1:0] r_top;
    logic [RW-1:0] n_top;
    logic [3:0]    r_fg;
    logic [3:0]    r_bg;
    logic [AW-1:0] r_sweep_addr;
    logic [AW-1:0] n_sweep_addr;
    logic [AW-1:0] r_sweep_end;
    logic [AW-1:0] n_sweep_end;
    logic [15:0]   r_rdata;
    logic [10:0]   r_pos;
    logic [15:0]   r_cell;

    t_op           w_op;
    logic [CW-1:0] w_col_c;
    logic [RW-1:0] w_row_c;
    logic [CW-1:0] w_put_col;
    logic [RW-1:0] w_put_row;
    logic          w_put_scroll;
    logic          w_put_write;
    logic [AW-1:0] w_addr;
    logic [AW-1:0] w_base;
    logic          w_last;
    logic [15:0]   w_blank;
    logic [15:0]   w_cell;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;

    assign w_op    = t_op'(i_operation);
    assign w_col_c = (int'(i_column) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(i_column);
    assign w_row_c = (int'(i_row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(i_row);
    assign w_blank = {r_bg, r_fg, CH_SPACE};
    assign w_cell  = {r_bg, r_fg, i_char_code};
    assign w_last  = (r_sweep_addr == r_sweep_end);
    assign w_base  = AW'(int'(r_top) * COLUMNS);

    always_comb begin
        logic [TW-1:0] v_tab;
        logic [TW-1:0] v_col;
        logic          v_adv;
        v_tab = '0;
        for (int k = NSTOPS; k >= 1; k--) begin
            if (k * TAB_WIDTH > int'(r_col)) begin
                v_tab = TW'(k * TAB_WIDTH);
            end
        end
        v_col       = TW'(r_col);
        v_adv       = 1'b0;
        w_put_write = 1'b0;
        case (i_char_code)
            CH_TAB: begin
                v_col = v_tab;
            end
            CH_NEWLINE: begin
                v_col = '0;
                v_adv = 1'b1;
            end
            CH_RETURN: begin
                v_col = '0;
            end
            default: begin
                w_put_write = 1'b1;
                v_col       = TW'(r_col) + 1'b1;
            end
        endcase
        if (int'(v_col) >= COLUMNS) begin
            v_col = '0;
            v_adv = 1'b1;
        end
        w_put_col    = CW'(v_col);
        w_put_row    = r_row;
        w_put_scroll = 1'b0;
        if (v_adv) begin
            if (int'(r_row) == ROWS - 1) begin
                w_put_scroll = 1'b1;
            end else begin
                w_put_row = r_row + 1'b1;
            end
        end
    end

    always_comb begin
        logic [CW-1:0] v_col;
        logic [RW:0]   v_prow;
        v_col  = (w_op == OP_READ) ? w_col_c : r_col;
        v_prow = (w_op == OP_READ) ? {1'b0, w_row_c} : {1'b0, r_row};
        v_prow = v_prow + {1'b0, r_top};
        if (int'(v_prow) >= ROWS) begin
            v_prow = v_prow - (RW + 1)'(ROWS);
        end
        w_addr = AW'(int'(v_prow) * COLUMNS + int'(v_col));
    end

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_top        = r_top;
        n_sweep_addr = r_sweep_addr;
        n_sweep_end  = r_sweep_end;
        if (i_cmd.exec) begin
            case (w_op)
                OP_PUT: begin
                    n_col = w_put_col;
                    n_row = w_put_row;
                    if (w_put_scroll) begin
                        n_top        = (int'(r_top) == ROWS - 1) ? '0 : r_top + 1'b1;
                        n_sweep_addr = w_base;
                        n_sweep_end  = w_base + AW'(COLUMNS - 1);
                    end
                end
                OP_MOVE: begin
                    n_col = w_col_c;
                    n_row = w_row_c;
                end
                OP_CLEAR: begin
                    n_col        = '0;
                    n_row        = '0;
                    n_top        = '0;
                    n_sweep_addr = '0;
                    n_sweep_end  = AW'(CELLS - 1);
                end
                default: begin
                    n_col = r_col;
                end
            endcase
        end else if (i_cmd.sweep && !w_last) begin
            n_sweep_addr = r_sweep_addr + 1'b1;
        end
    end

    assign w_we    = (i_cmd.exec && w_op == OP_PUT && w_put_write) || i_cmd.sweep;
    assign w_waddr = i_cmd.sweep ? r_sweep_addr : w_addr;
    assign w_wdata = i_cmd.sweep ? (i_cmd.init ? BLANK_RESET : w_blank) : w_cell;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.exec) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos  <= 11'(int'(n_row) * COLUMNS + int'(n_col));
            r_cell <= i_cmd.load_read ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_top        <= '0;
            r_sweep_addr <= '0;
            r_sweep_end  <= AW'(CELLS - 1);
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_top        <= n_top;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_end  <= n_sweep_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FG: begin
                    r_fg <= i_cfg_data;
                end
                CFG_BG: begin
                    r_bg <= i_cfg_data;
                end
                default: begin
                    r_fg <= r_fg;
                end
            endcase
        end
    end

    assign o_sts.op           = w_op;
    assign o_sts.scroll       = w_put_scroll;
    assign o_sts.last         = w_last;
    assign o_cursor_position  = r_pos;
    assign o_cell_value       = r_cell;

endmodule

// File: design/text_console_writer.sv
// Put without scroll and move give their word in the cycle after acceptance; a read
// registers the cell, then loads it into the output in ST_READ. A put that scrolls and
// clear blank cells in ST_SWEEP through the single write port of the cell memory, one
// cell per cycle, and load the word at the last cell. Throughput is one word per cycle
// for puts and moves when the output is taken at once. Reset is synchronous and active
// low; after it a clearing pass fills every cell with 0x0F20 while input stays stalled.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_operation,
    input  logic [7:0]            i_char_code,
    input  logic [6:0]            i_column,
    input  logic [4:0]            i_row,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [10:0]           o_cursor_position,
    output logic [15:0]           o_cell_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tcw_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_operation       (i_operation),
        .i_char_code       (i_char_code),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_cursor_position (o_cursor_position),
        .o_cell_value      (o_cell_value)
    );

endmodule

// File: design/tcw_checker.sv
module tcw_assert
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_operation,
    input logic [6:0]  i_column,
    input logic [4:0]  i_row,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [10:0] o_cursor_position,
    input logic [15:0] o_cell_value
);

    int          w_col;
    int          w_row;
    logic [10:0] w_mv_pos;
    logic        w_in_acc;

    assign w_col    = (int'(i_column) > COLUMNS - 1) ? COLUMNS - 1 : int'(i_column);
    assign w_row    = (int'(i_row) > ROWS - 1) ? ROWS - 1 : int'(i_row);
    assign w_mv_pos = 11'(w_row * COLUMNS + w_col);
    assign w_in_acc = i_in_valid && !o_in_stall;

    // A stalled result word must hold its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_cursor_position) && $stable(o_cell_value))
        else $error("output word changed while stalled");

    // A move gives its word in the next cycle with the clamped position and no cell data.
    a_move_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_operation == OP_MOVE |=>
            o_out_valid && o_cursor_position == $past(w_mv_pos) && o_cell_value == 16'd0)
        else $error("move result wrong");

    // The clearing pass after reset keeps input stalled.
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input accepted during clearing pass");

    // The reported cursor lies on the screen.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_cursor_position) < COLUMNS * ROWS)
        else $error("cursor position off screen");

endmodule

bind text_console_writer tcw_assert #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_assert (.*);

// File: sim/tcw_checker.sv
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_operation,
    input  logic [7:0]            i_char_code,
    input  logic [6:0]            i_column,
    input  logic [4:0]            i_row,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [10:0]           i_cursor_position,
    input  logic [15:0]           i_cell_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_outstanding,
    output int                    o_errors
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [10:0] position;
        logic [15:0] contents;
    } t_console_word;

    logic [15:0]   screen [CELLS];
    int            cur_col;
    int            cur_row;
    int            top_row;
    logic [3:0]    fg;
    logic [3:0]    bg;
    t_console_word awaited_words [$];
    int            errors = 0;

    function automatic logic [15:0] colored(input logic [7:0] ch);
        return {bg, fg, ch};
    endfunction

    function automatic int cell_at(input int col, input int lrow);
        return ((lrow + top_row) % ROWS) * COLUMNS + col;
    endfunction

    // The top row offset makes the scroll circular: only the new bottom row is blanked.
    function automatic void next_line();
        cur_row++;
        if (cur_row >= ROWS) begin
            top_row = (top_row + 1) % ROWS;
            for (int x = 0; x < COLUMNS; x++) begin
                screen[cell_at(x, ROWS - 1)] = colored(CH_SPACE);
            end
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        case (ch)
            CH_TAB: begin
                cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
            end
            CH_NEWLINE: begin
                cur_col = 0;
                next_line();
            end
            CH_RETURN: begin
                cur_col = 0;
            end
            default: begin
                screen[cell_at(cur_col, cur_row)] = colored(ch);
                cur_col++;
            end
        endcase
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            next_line();
        end
    endfunction

    function automatic t_console_word console_step(input t_op op, input logic [7:0] ch,
                                                   input logic [6:0] col_in,
                                                   input logic [4:0] row_in);
        int            col;
        int            lrow;
        t_console_word word;
        col  = col_in;
        lrow = row_in;
        if (col > COLUMNS - 1) col = COLUMNS - 1;
        if (lrow > ROWS - 1) lrow = ROWS - 1;
        word.contents = '0;
        case (op)
            OP_PUT: begin
                put_char(ch);
            end
            OP_READ: begin
                word.contents = screen[cell_at(col, lrow)];
            end
            OP_MOVE: begin
                cur_col = col;
                cur_row = lrow;
            end
            default: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i] = colored(CH_SPACE);
                end
                cur_col = 0;
                cur_row = 0;
                top_row = 0;
            end
        endcase
        word.position = 11'(cur_row * COLUMNS + cur_col);
        return word;
    endfunction

    function automatic void note_error(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_console_word got;
        t_console_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                screen[i] = BLANK_RESET;
            end
            cur_col = 0;
            cur_row = 0;
            top_row = 0;
            fg      = FG_RESET;
            bg      = BG_RESET;
            awaited_words.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FG) begin
                    fg = i_cfg_data;
                end else if (i_cfg_index == CFG_BG) begin
                    bg = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_cursor_position, i_cell_value};
                if (awaited_words.size() == 0) begin
                    note_error("word with nothing awaited, cursor", 16'd0, 16'(got.position));
                end else begin
                    want = awaited_words.pop_front();
                    if (got.position !== want.position) begin
                        note_error("cursor position", 16'(want.position), 16'(got.position));
                    end
                    if (got.contents !== want.contents) begin
                        note_error("cell value", want.contents, got.contents);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_words.push_back(console_step(t_op'(i_operation), i_char_code,
                                                     i_column, i_row));
            end
        end
        o_outstanding <= awaited_words.size();
        o_errors      <= errors;
    end

endmodule

// File: sim/tb_top.sv
module tb_top
    import tcw_pkg::*;
();

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_WIDTH   = 8;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 185;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic [1:0]            operation  = OP_READ;
    logic [7:0]            char_code  = '0;
    logic [6:0]            column     = '0;
    logic [4:0]            row        = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [10:0]           cursor_position;
    logic [15:0]           cell_value;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_FG;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    int                    pending;
    int                    errors;

    bit hold_req    = 1'b0;
    bit quiet       = 1'b0;
    int clears_left = 12;

    always #5 clk = ~clk;

    text_console_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_WIDTH(TAB_WIDTH)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (operation),
        .i_char_code      (char_code),
        .i_column         (column),
        .i_row            (row),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_cursor_position(cursor_position),
        .o_cell_value     (cell_value),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    tcw_checker #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_WIDTH(TAB_WIDTH)
    ) checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_operation      (operation),
        .i_char_code      (char_code),
        .i_column         (column),
        .i_row            (row),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_cursor_position(cursor_position),
        .i_cell_value     (cell_value),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_outstanding    (pending),
        .o_errors         (errors)
    );

    function automatic int sender_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input t_op op, input logic [7:0] ch, input logic [6:0] col,
                             input logic [4:0] lrow, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        char_code <= ch;
        column    <= col;
        row       <= lrow;
        do @(posedge clk); while (in_stall);
    endtask

    // Most traffic is printable text with line controls, and cursor moves and reads
    // are pulled toward the bottom rows where wraps and scrolls happen.
    task automatic send_random();
        int         r;
        t_op        op;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] lrow;
        r    = $urandom_range(0, 99);
        ch   = 8'($urandom);
        col  = 7'($urandom);
        lrow = 5'($urandom);
        if (r < 60 || (r >= 97 && clears_left == 0)) begin
            op = OP_PUT;
            r  = $urandom_range(0, 99);
            if (r < 70) begin
                ch = 8'($urandom_range(32, 126));
            end else if (r < 80) begin
                ch = CH_NEWLINE;
            end else if (r < 86) begin
                ch = CH_TAB;
            end else if (r < 90) begin
                ch = CH_RETURN;
            end
        end else if (r < 97) begin
            op = (r < 76) ? OP_READ : OP_MOVE;
            r  = $urandom_range(0, 9);
            if (r < 5) begin
                col  = 7'($urandom_range(0, 15));
                lrow = 5'($urandom_range(18, 24));
            end else if (r < 7) begin
                col  = 7'($urandom_range(64, 79));
                lrow = 5'($urandom_range(20, 24));
            end else if (r < 9) begin
                col  = 7'($urandom_range(0, 79));
                lrow = 5'($urandom_range(0, 24));
            end
        end else begin
            op = OP_CLEAR;
            clears_left--;
        end
        send_word(op, ch, col, lrow, sender_gap());
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (CELLS + 16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat (stall_len()) @(posedge clk);
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_word(OP_READ, 8'h00, 7'd0, 5'd0, 0);
        send_word(OP_READ, 8'hFF, 7'd127, 5'd31, sender_gap());
        send_word(OP_PUT, 8'h41, 7'd0, 5'd0, sender_gap());
        send_word(OP_PUT, 8'hFF, 7'd127, 5'd31, sender_gap());
        send_word(OP_PUT, 8'h00, 7'd0, 5'd0, sender_gap());
        send_word(OP_PUT, CH_TAB, 7'd0, 5'd0, sender_gap());
        send_word(OP_PUT, CH_RETURN, 7'd0, 5'd0, sender_gap());
        send_word(OP_PUT, CH_NEWLINE, 7'd0, 5'd0, sender_gap());
        send_word(OP_READ, 8'h00, 7'd1, 5'd0, sender_gap());
        send_word(OP_MOVE, 8'h00, 7'd72, 5'd3, sender_gap());
        send_word(OP_PUT, CH_TAB, 7'd0, 5'd0, sender_gap());
        send_word(OP_MOVE, 8'h00, 7'd127, 5'd31, sender_gap());
        send_word(OP_PUT, 8'h7E, 7'd0, 5'd0, sender_gap());
        send_word(OP_READ, 8'h00, 7'd79, 5'd23, sender_gap());
        send_word(OP_READ, 8'h00, 7'd0, 5'd24, sender_gap());
        send_word(OP_MOVE, 8'h00, 7'd0, 5'd24, sender_gap());
        send_word(OP_PUT, CH_NEWLINE, 7'd0, 5'd0, sender_gap());
        send_word(OP_READ, 8'h00, 7'd0, 5'd0, sender_gap());
        send_word(OP_CLEAR, 8'h00, 7'd0, 5'd0, sender_gap());
        send_word(OP_READ, 8'h00, 7'd40, 5'd12, sender_gap());
        send_word(OP_MOVE, 8'h00, 7'd79, 5'd24, sender_gap());
        send_word(OP_PUT, 8'h80, 7'd0, 5'd0, sender_gap());
        send_word(OP_READ, 8'h00, 7'd79, 5'd23, sender_gap());

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                in_valid <= 1'b0;
                drain();
                case (phase)
                    1: begin
                        write_reg(CFG_FG, 4'd0);
                        write_reg(CFG_BG, 4'd0);
                    end
                    2: begin
                        write_reg(CFG_FG, 4'd15);
                        write_reg(CFG_BG, 4'd15);
                    end
                    3: begin
                        write_reg(CFG_FG, 4'($urandom));
                        write_reg(CFG_BG, 4'($urandom));
                    end
                    4: begin
                        write_reg(CFG_FG, 4'd15);
                        write_reg(CFG_BG, 4'd0);
                    end
                    default: begin
                        write_reg(CFG_FG, 4'd0);
                        write_reg(CFG_BG, 4'd15);
                    end
                endcase
            end
            quiet = (phase == 2 || phase == 4);
            if (phase == 2) hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_random();
            end
        end

        in_valid <= 1'b0;
        quiet = 1'b0;
        drain();
        if (errors == 0 && pending == 0) begin
            $display("text_console_writer regression: pass");
        end else begin
            $display("text_console_writer regression: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("text_console_writer regression: fail");
        $finish;
    end

endmodule

// File: text_console_writer.f
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_dp.sv
design/text_console_writer.sv
design/tcw_checker.sv
sim/tcw_checker.sv
sim/tb_top.sv
